[rtl/core/brat_pkg.sv]
`timescale 1ns / 1ps

package brat_pkg;

    localparam int VALUE_W      = 48;
    localparam int NUM_W        = 32;
    localparam int DEN_W        = 16;
    localparam int STEP_W       = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int DEF_FRAC_BITS = 32;
    localparam int DEF_INT_BITS  = 16;

    localparam logic [DEN_W-1:0]  RST_MAX_DEN   = DEN_W'(10000);
    localparam logic [STEP_W-1:0] RST_MAX_STEPS = STEP_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = CFG_IDX_W'(1);

    typedef struct packed {
        logic load;
        logic mul;
        logic err;
        logic mul2;
        logic cmp;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic over;
    } t_dp_sts;

endpackage

[rtl/core/brat_datapath.sv]
`timescale 1ns / 1ps

module brat_datapath
    import brat_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int INT_BITS  = DEF_INT_BITS
) (
    input  logic               i_clk,
    input  logic [VALUE_W-1:0] i_value_fixed,
    input  logic [DEN_W-1:0]   i_max_den,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic [NUM_W-1:0]   o_numerator,
    output logic [DEN_W-1:0]   o_denominator
);

    localparam int PW = FRAC_BITS + DEN_W;
    localparam int XW = PW + DEN_W;
    localparam int SW = INT_BITS + DEN_W + 1;
    localparam int EW = VALUE_W + FRAC_BITS + INT_BITS;

    logic [FRAC_BITS-1:0] r_frac;
    logic [INT_BITS-1:0]  r_int;
    logic [DEN_W-1:0]     r_lp, r_lq, r_up, r_uq;
    logic [DEN_W-1:0]     r_mp, r_mq;
    logic [PW-1:0]        r_prod;
    logic [PW-1:0]        r_err;
    logic [XW-1:0]        r_x1, r_x2;
    logic [DEN_W-1:0]     r_bp, r_bq;
    logic [PW-1:0]        r_be;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;

    logic [EW-1:0]        value_ext;
    logic [FRAC_BITS-1:0] in_frac;
    logic [FRAC_BITS:0]   one_err;
    logic [DEN_W:0]       med_p, med_q;
    logic [PW-1:0]        p_shift;
    logic                 above;
    logic [SW-1:0]        num_sum;

    assign value_ext = EW'(i_value_fixed);
    assign in_frac   = i_value_fixed[FRAC_BITS-1:0];
    // error of 1/1 is 2^F - f
    assign one_err   = {1'b1, {FRAC_BITS{1'b0}}} - (FRAC_BITS+1)'(in_frac);

    assign med_p     = (DEN_W+1)'(r_lp) + (DEN_W+1)'(r_up);
    assign med_q     = (DEN_W+1)'(r_lq) + (DEN_W+1)'(r_uq);
    assign o_sts.over = med_q > (DEN_W+1)'(i_max_den);

    assign p_shift   = {r_mp, {FRAC_BITS{1'b0}}};
    assign above     = p_shift > r_prod;

    assign num_sum   = SW'(r_int) * SW'(r_bq) + SW'(r_bp);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frac <= in_frac;
            r_int  <= value_ext[FRAC_BITS +: INT_BITS];
            r_lp   <= '0;
            r_lq   <= DEN_W'(1);
            r_up   <= DEN_W'(1);
            r_uq   <= DEN_W'(1);
            r_bq   <= DEN_W'(1);
            if (one_err < (FRAC_BITS+1)'(in_frac)) begin
                r_bp <= DEN_W'(1);
                r_be <= PW'(one_err);
            end else begin
                r_bp <= '0;
                r_be <= PW'(in_frac);
            end
        end
        if (i_cmd.mul) begin
            r_mp   <= med_p[DEN_W-1:0];
            r_mq   <= med_q[DEN_W-1:0];
            r_prod <= PW'(r_frac) * med_q[DEN_W-1:0];
        end
        if (i_cmd.err) begin
            r_err <= above ? (p_shift - r_prod) : (r_prod - p_shift);
            // move the bound on the mediant's side of the fraction
            if (above) begin
                r_up <= r_mp;
                r_uq <= r_mq;
            end else begin
                r_lp <= r_mp;
                r_lq <= r_mq;
            end
        end
        if (i_cmd.mul2) begin
            r_x1 <= XW'(r_err) * r_bq;
            r_x2 <= XW'(r_be) * r_mq;
        end
        // strictly smaller only: ties keep the earlier candidate
        if (i_cmd.cmp && (r_x1 < r_x2)) begin
            r_bp <= r_mp;
            r_bq <= r_mq;
            r_be <= r_err;
        end
        if (i_cmd.fin) begin
            r_num <= NUM_W'(num_sum);
            r_den <= r_bq;
        end
    end

    assign o_numerator   = r_num;
    assign o_denominator = r_den;

endmodule

[rtl/core/brat_ctrl.sv]
`timescale 1ns / 1ps

module brat_ctrl
    import brat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [STEP_W-1:0] i_max_steps,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ERR,
        S_MUL2,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_pend     = 1'b0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                // finish the previous step's compare while starting the next
                o_cmd.cmp = r_pend;
                n_pend    = 1'b0;
                if ((r_cnt == i_max_steps) || i_sts.over) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_cnt      = r_cnt + STEP_W'(1);
                n_pend     = 1'b1;
                n_state    = S_MUL;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/best_rational_approximation.sv]
`timescale 1ns / 1ps

// Best rational approximation p/q of an unsigned fixed-point value, found by
// a Stern-Brocot walk over the fraction bits.
// Input channel: i_in_valid / o_in_stall carry i_value_fixed; a beat is taken
// when valid is high and stall is low. Stall stays high while a value is
// being worked on, so one value is in flight at a time.
// Output channel: o_out_valid / i_out_stall carry o_numerator and
// o_denominator from an output register. While the receiver stalls, the
// result holds and the next value can already be accepted and processed;
// its final load waits until the register is free.
// Steps: each mediant step runs a fraction multiply, then the error and bound
// update, then the cross multiply; the compare overlaps the next step's
// fraction multiply. The number of steps is bounded by max_steps and by
// max_denominator. The next value is accepted in the cycle after the result
// loads.
// Configuration: i_cfg_valid / o_cfg_ready, always ready; index 0 sets
// max_denominator, index 1 sets max_steps, other indexes are dropped.
// Reset (synchronous, active low) empties the output register, returns the
// controller to idle and restores max_denominator 10000, max_steps 1000.
module best_rational_approximation
    import brat_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int INT_BITS  = DEF_INT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_W-1:0]    i_value_fixed,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [NUM_W-1:0]      o_numerator,
    output logic [DEN_W-1:0]      o_denominator,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DEN_W-1:0]  r_max_den;
    logic [STEP_W-1:0] r_max_steps;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_den   <= RST_MAX_DEN;
            r_max_steps <= RST_MAX_STEPS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_DEN:   r_max_den   <= i_cfg_data[DEN_W-1:0];
                CFG_MAX_STEPS: r_max_steps <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    brat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_max_steps (r_max_steps),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    brat_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_value_fixed (i_value_fixed),
        .i_max_den     (r_max_den),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator)
    );

endmodule
